@@ rtl/core/tt8_pkg.sv @@
// ----------------------------------------------------------------------------
// tt8_pkg: shared types and helpers for the tag text transcoder
// Payload structs, sequencer states, buffer sizes and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package tt8_pkg;

    localparam int MAX_FIELD_BYTES = 256;
    localparam int MAX_OUT_BYTES   = 64;
    localparam int FA_W = $clog2(MAX_FIELD_BYTES);
    localparam int OA_W = $clog2(MAX_OUT_BYTES);
    localparam int FC_W = FA_W + 1;
    localparam int CAP_W = 7;

    // encoding codes
    localparam logic [1:0] ENC_SINGLE  = 2'd0;
    localparam logic [1:0] ENC_U16_BOM = 2'd1;
    localparam logic [1:0] ENC_U16_BE  = 2'd2;
    localparam logic [1:0] ENC_UTF8    = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       last_byte;
        logic [1:0] encoding;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_result;
        logic [5:0] total_length;
        logic       overflow;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_BOM_F, S_BOM_G, S_DEC, S_FETCH, S_GOT, S_CP,
        S_PUT, S_TR_F, S_TR_G, S_EM_F, S_EM_G, S_EMPTY
    } t_state;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_enc;

    // control codes become a space
    function automatic logic [20:0] clean_cp(input logic [20:0] cp);
        return (cp < 21'h20 || cp == 21'h7F) ? 21'h20 : cp;
    endfunction

    // code point to UTF-8 bytes, b[0] first
    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e.b = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n = 3'd2;
        end else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ rtl/core/tag_text_to_utf8_top.sv @@
// ----------------------------------------------------------------------------
// tag_text_to_utf8_top: tag text field to bounded UTF-8 transcoder
// Buffers a field, then a byte-wide sequencer decodes, trims and emits it.
// ----------------------------------------------------------------------------
// Loading: one byte per cycle, busy stays low until the last item.
// Conversion: a setup state (plus BOM sniffing), then a fetch and a decode state
//   per field byte, dispatch and encode per character, a write per UTF-8 byte.
// Trim: read and test each byte from the end; emit: read and output each result.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (synchronous, active low) clears the field state and sets capacity 64.
module tag_text_to_utf8_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tt8_pkg::t_in_item i_item,
    output logic              o_result_valid,
    output tt8_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);
    import tt8_pkg::*;

    t_state r_state, n_state;
    logic [FC_W-1:0]  r_count, n_count, r_pos, n_pos;
    logic [8:0]       r_high, n_high;
    logic             r_cyr, n_cyr, r_dropped, n_dropped, r_le, n_le;
    logic [1:0]       r_enc, n_enc;
    logic [CAP_W-1:0] r_cap, n_cap, r_cape, n_cape, r_used, n_used;
    logic [OA_W-1:0]  r_j, n_j;
    logic [2:0]       r_k, n_k;
    logic [7:0]       r_a, n_a;
    logic [15:0]      r_hi, n_hi;
    logic [20:0]      r_cp, n_cp;
    t_enc             r_e, n_e;

    logic             accept;
    logic             f_we;
    logic [7:0]       f_rdata, res_rdata;
    logic             res_we;
    logic [OA_W-1:0]  res_raddr;
    logic [15:0]      unit;
    logic [2:0]       u8w;
    logic [20:0]      cp1;
    t_enc             enc;
    logic [FC_W:0]    pos_ext, cnt_ext;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign f_we        = accept && i_item.byte_present && (r_count < FC_W'(MAX_FIELD_BYTES));

    tt8_ram #(.WIDTH(8), .DEPTH(MAX_FIELD_BYTES)) u_field (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(r_count[FA_W-1:0]),
        .i_wdata(i_item.in_byte), .i_raddr(r_pos[FA_W-1:0]), .o_rdata(f_rdata)
    );

    tt8_ram #(.WIDTH(8), .DEPTH(MAX_OUT_BYTES)) u_result (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(r_used[OA_W-1:0]),
        .i_wdata(r_e.b[r_k[1:0]]), .i_raddr(res_raddr), .o_rdata(res_rdata)
    );

    assign res_we    = (r_state == S_PUT) &&
                       ((r_k != 3'd0) || (r_used + CAP_W'(r_e.n) + 7'd1 <= r_cape));
    assign res_raddr = (r_state == S_TR_F) ? r_used[OA_W-1:0] - OA_W'(1) : r_j;

    // decode helpers
    assign unit    = r_le ? {f_rdata, r_a} : {r_a, f_rdata};
    assign pos_ext = {1'b0, r_pos};
    assign cnt_ext = {1'b0, r_count};
    assign u8w     = (f_rdata >= 8'hF0) ? 3'd4 : (f_rdata >= 8'hE0) ? 3'd3 :
                     (f_rdata >= 8'hC0) ? 3'd2 : 3'd1;
    assign enc     = utf8_enc(clean_cp(r_cp));

    // single-byte code point, CP1251 letters when the field qualifies
    always_comb begin
        cp1 = {13'd0, f_rdata};
        if (f_rdata >= 8'h80 && r_cyr && r_high >= 9'd4) begin
            if (f_rdata == 8'hA8)      cp1 = 21'h401;
            else if (f_rdata == 8'hB8) cp1 = 21'h451;
            else                       cp1 = 21'h350 + {13'd0, f_rdata};
        end
    end

    // next state and datapath
    always_comb begin
        n_state = r_state; n_count = r_count; n_pos = r_pos; n_high = r_high;
        n_cyr = r_cyr; n_dropped = r_dropped; n_le = r_le; n_enc = r_enc;
        n_cap = r_cap; n_cape = r_cape; n_used = r_used; n_j = r_j; n_k = r_k;
        n_a = r_a; n_hi = r_hi; n_cp = r_cp; n_e = r_e;

        if (i_cfg_valid && o_cfg_ready) begin
            n_cap = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_enc = i_item.encoding;
                    if (i_item.byte_present) begin
                        if (f_we) begin
                            n_count = r_count + FC_W'(1);
                            if (i_item.in_byte >= 8'h80) begin
                                if (!(i_item.in_byte == 8'hA8 || i_item.in_byte == 8'hB8 ||
                                      i_item.in_byte >= 8'hC0)) n_cyr = 1'b0;
                                if (r_high < 9'd511) n_high = r_high + 9'd1;
                            end
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                    if (i_item.last_byte) n_state = S_START;
                end
            end
            S_START: begin
                n_cape = (r_cap > CAP_W'(MAX_OUT_BYTES)) ? CAP_W'(MAX_OUT_BYTES) : r_cap;
                n_used = '0;
                n_pos  = '0;
                n_k    = '0;
                n_le   = (r_enc != ENC_U16_BE);
                if (r_cap == '0 || r_count == '0) n_state = S_TR_F;
                else if (r_enc == ENC_U16_BOM && r_count >= FC_W'(2)) n_state = S_BOM_F;
                else n_state = S_DEC;
            end
            S_BOM_F: n_state = S_BOM_G;
            S_BOM_G: begin
                if (r_k == 3'd0) begin
                    n_a = f_rdata; n_pos = FC_W'(1); n_k = 3'd1; n_state = S_BOM_F;
                end else begin
                    n_pos = '0;
                    if (r_a == 8'hFF && f_rdata == 8'hFE) n_pos = FC_W'(2);
                    else if (r_a == 8'hFE && f_rdata == 8'hFF) begin
                        n_le = 1'b0; n_pos = FC_W'(2);
                    end else if (r_a == 8'h00 && f_rdata != 8'h00) n_le = 1'b0;
                    else if (r_a <= 8'h08 && f_rdata > 8'h08) n_le = 1'b0;
                    n_k = '0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_k = '0;
                if (r_enc == ENC_U16_BOM || r_enc == ENC_U16_BE)
                    n_state = (pos_ext + 10'd1 < cnt_ext) ? S_FETCH : S_TR_F;
                else
                    n_state = (r_pos < r_count) ? S_FETCH : S_TR_F;
            end
            S_FETCH: n_state = S_GOT;
            S_GOT: begin
                case (r_enc)
                    ENC_SINGLE: begin
                        if (f_rdata == 8'h00) n_state = S_TR_F;
                        else begin
                            n_cp = cp1; n_pos = r_pos + FC_W'(1); n_state = S_CP;
                        end
                    end
                    ENC_UTF8: begin
                        if (r_k == 3'd0) begin
                            if (f_rdata == 8'h00 ||
                                pos_ext + {7'd0, u8w} > cnt_ext) n_state = S_TR_F;
                            else if (u8w == 3'd1) begin
                                if (f_rdata >= 8'h80) n_state = S_TR_F;
                                else begin
                                    n_cp = {13'd0, f_rdata};
                                    n_pos = r_pos + FC_W'(1);
                                    n_state = S_CP;
                                end
                            end else begin
                                n_e.b[0] = f_rdata; n_e.n = u8w;
                                n_pos = r_pos + FC_W'(1); n_k = 3'd1;
                                n_state = S_FETCH;
                            end
                        end else begin
                            if (f_rdata[7:6] != 2'b10) n_state = S_TR_F;
                            else begin
                                n_e.b[r_k[1:0]] = f_rdata;
                                n_pos = r_pos + FC_W'(1);
                                if (r_k + 3'd1 == r_e.n) begin
                                    n_k = '0; n_state = S_PUT;
                                end else begin
                                    n_k = r_k + 3'd1; n_state = S_FETCH;
                                end
                            end
                        end
                    end
                    default: begin
                        // UTF-16: two bytes a unit, optional low surrogate
                        case (r_k)
                            3'd0, 3'd2: begin
                                n_a = f_rdata; n_pos = r_pos + FC_W'(1);
                                n_k = r_k + 3'd1; n_state = S_FETCH;
                            end
                            3'd1: begin
                                n_pos = r_pos + FC_W'(1);
                                if (unit == 16'h0) n_state = S_TR_F;
                                else if (unit >= 16'hD800 && unit <= 16'hDBFF &&
                                         pos_ext + 10'd2 < cnt_ext) begin
                                    n_hi = unit; n_k = 3'd2; n_state = S_FETCH;
                                end else begin
                                    n_cp = {5'd0, unit}; n_state = S_CP;
                                end
                            end
                            default: begin
                                if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                                    n_cp = 21'h10000 + {1'b0, r_hi[9:0], unit[9:0]};
                                    n_pos = r_pos + FC_W'(1);
                                end else begin
                                    n_cp = {5'd0, r_hi};
                                    n_pos = r_pos - FC_W'(1);
                                end
                                n_state = S_CP;
                            end
                        endcase
                    end
                endcase
            end
            S_CP: begin
                n_k = '0;
                if (r_cp >= 21'hD800 && r_cp <= 21'hDFFF) n_state = S_DEC;
                else begin
                    n_e = enc; n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!res_we) n_state = S_TR_F;
                else begin
                    n_used = r_used + CAP_W'(1);
                    if (r_k + 3'd1 == r_e.n) n_state = S_DEC;
                    else n_k = r_k + 3'd1;
                end
            end
            S_TR_F: n_state = (r_used == '0) ? S_EMPTY : S_TR_G;
            S_TR_G: begin
                if (res_rdata == 8'h20 || res_rdata == 8'h09) begin
                    n_used = r_used - CAP_W'(1); n_state = S_TR_F;
                end else begin
                    n_j = '0; n_state = S_EM_F;
                end
            end
            S_EM_F: n_state = S_EM_G;
            S_EM_G: begin
                n_j = r_j + OA_W'(1);
                n_state = ({1'b0, r_j} + CAP_W'(1) == r_used) ? S_IDLE : S_EM_F;
            end
            S_EMPTY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        // field state returns to reset after the last result
        if (n_state == S_IDLE && r_state != S_IDLE) begin
            n_count = '0; n_high = '0; n_cyr = 1'b1; n_enc = ENC_SINGLE; n_dropped = 1'b0;
        end
    end

    // outputs
    always_comb begin
        busy = (r_state != S_IDLE);
        o_result_valid = 1'b0;
        o_result = '0;
        o_result.overflow = r_dropped;
        case (r_state)
            S_EM_G: begin
                o_result_valid = 1'b1;
                o_result.out_byte = res_rdata;
                o_result.byte_valid = 1'b1;
                o_result.last_result = ({1'b0, r_j} + CAP_W'(1) == r_used);
                o_result.total_length = r_used[5:0];
            end
            S_EMPTY: begin
                o_result_valid = 1'b1;
                o_result.last_result = 1'b1;
            end
            default: o_result_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_high <= '0; r_cyr <= 1'b1;
            r_enc <= ENC_SINGLE; r_dropped <= 1'b0; r_cap <= CAP_W'(MAX_OUT_BYTES);
            r_used <= '0; r_j <= '0; r_k <= '0; r_pos <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_high <= n_high; r_cyr <= n_cyr;
            r_enc <= n_enc; r_dropped <= n_dropped; r_cap <= n_cap;
            r_used <= n_used; r_j <= n_j; r_k <= n_k; r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cape <= n_cape; r_le <= n_le; r_a <= n_a; r_hi <= n_hi; r_cp <= n_cp; r_e <= n_e;
    end

    // checks
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy) else $error("result beat while idle");
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_we |-> (r_used + 7'd1 < r_cape)) else $error("write past capacity");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_result) |=> !busy) else $error("no idle after last");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FC_W'(MAX_FIELD_BYTES)) else $error("field count overrun");
endmodule

@@ rtl/core/tt8_ram.sv @@
// ----------------------------------------------------------------------------
// tt8_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tt8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
